@@ rtl/wsd_pkg.sv @@
// Shared types and codes for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DROP    = 3'd6
  } phase_t;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_TRUNC  = 2'd2
  } kind_t;

  localparam logic [6:0] LEN_ESC16 = 7'd126;
  localparam logic [6:0] LEN_ESC64 = 7'd127;
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;  // eight bytes, count wraps
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        mask_present;
    logic [31:0] key_word;
    logic [63:0] payload_size;
    logic [7:0]  payload_data;
    logic        frame_done;
  } out_beat_t;

endpackage

@@ rtl/websocket_frame_deframer.sv @@
// Top level: WebSocket frame deframer, receive-side base framing parser.
`timescale 1ns / 1ps

// Takes a received buffer one byte per beat (buffer_end marks its last byte)
// and parses one frame from the buffer's start: FIN and opcode, mask bit and
// 7-bit length, an optional 16- or 64-bit big-endian length (both unsigned),
// and an optional 4-byte mask key. When the header is complete one header
// result (kind 0) goes out; each payload byte then goes out XOR-unmasked
// with key byte (index mod 4) as kind 1, the frame's header fields repeated,
// frame_done set on the last one (or on the header of an empty frame). A
// buffer that ends before the frame is complete yields one kind 2 result
// with every other field zero. Bytes after a complete frame are dropped
// silently; every buffer end restarts the parser. Throughput is one byte
// per clock while in_stall is low: each beat is parsed by a single state
// update whose result is registered in the output register or skid stage.
// in_stall rises only when both the output register and its skid stage
// hold results the sink has not taken; the skid stage absorbs one extra
// result so that in_stall is a register and not a path from out_stall.
// The widest logic per cycle is the 64-bit remaining-byte down-counter and
// its compare with one.

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_beat_t  in_beat,
  output logic      in_stall,
  output logic      out_valid,
  output out_beat_t out_beat,
  input  logic      out_stall
);

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opc_r, opc_nxt;
  logic        mask_r, mask_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] remain_r, remain_nxt;   // payload bytes still to come
  logic [1:0]  kidx_r, kidx_nxt;       // key byte index (payload index mod 4)

  logic        in_acc;
  logic        buf_stall;
  logic        res_valid;
  out_beat_t   res_beat;

  logic [7:0]  b;
  logic        b_end;
  logic [6:0]  l7;
  logic [2:0]  cnt_inc;
  logic        hdr_fin;     // header completes on this byte
  logic        last;
  logic [7:0]  kb;

  assign in_acc  = in_valid && !in_stall;
  assign b       = in_beat.data_byte;
  assign b_end   = in_beat.buffer_end;
  assign l7      = b[6:0];
  assign cnt_inc = cnt_r + 3'd1;
  assign last    = (remain_r == 64'd1);

  always_comb begin
    case (kidx_r)
      2'd0:    kb = key_r[31:24];
      2'd1:    kb = key_r[23:16];
      2'd2:    kb = key_r[15:8];
      default: kb = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    fin_nxt    = fin_r;
    opc_nxt    = opc_r;
    mask_nxt   = mask_r;
    key_nxt    = key_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    kidx_nxt   = kidx_r;
    hdr_fin    = 1'b0;
    res_valid  = 1'b0;
    res_beat   = '0;

    unique case (phase_r)
      PH_HDR0: begin
        fin_nxt    = b[7];
        opc_nxt    = b[3:0];
        mask_nxt   = 1'b0;
        key_nxt    = '0;
        len_nxt    = '0;
        remain_nxt = '0;
        kidx_nxt   = '0;
        cnt_nxt    = '0;
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_nxt = b[7];
        cnt_nxt  = '0;
        if (l7 == LEN_ESC16) begin
          phase_nxt = PH_EXT16;
        end else if (l7 == LEN_ESC64) begin
          phase_nxt = PH_EXT64;
        end else begin
          len_nxt = {57'd0, l7};
          if (b[7]) phase_nxt = PH_KEY;
          else      hdr_fin   = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_nxt = {len_r[55:0], b};
        cnt_nxt = cnt_inc;
        if (cnt_inc == ((phase_r == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
          cnt_nxt = '0;
          if (mask_r) phase_nxt = PH_KEY;
          else        hdr_fin   = 1'b1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], b};
        cnt_nxt = cnt_inc;
        if (cnt_inc == KEY_BYTES) begin
          cnt_nxt = '0;
          hdr_fin = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        if (!(b_end && !last)) begin
          res_beat.kind         = KIND_DATA;
          res_beat.fin_flag     = fin_r;
          res_beat.frame_opcode = opc_r;
          res_beat.mask_present = mask_r;
          res_beat.key_word     = key_r;
          res_beat.payload_size = len_r;
          res_beat.payload_data = b ^ kb;
          res_beat.frame_done   = last;
        end else begin
          res_beat.kind = KIND_TRUNC;
        end
        remain_nxt = remain_r - 64'd1;
        kidx_nxt   = kidx_r + 2'd1;
        if (last) phase_nxt = PH_DROP;
      end
      PH_DROP: begin
      end
      default: begin
      end
    endcase

    // Header complete: empty frame finishes here, else payload follows unless the buffer ends here
    if (hdr_fin) begin
      if (len_nxt == 64'd0) begin
        phase_nxt = PH_DROP;
        res_valid = 1'b1;
        res_beat.kind         = KIND_HEADER;
        res_beat.fin_flag     = fin_nxt;
        res_beat.frame_opcode = opc_nxt;
        res_beat.mask_present = mask_nxt;
        res_beat.key_word     = key_nxt;
        res_beat.payload_size = len_nxt;
        res_beat.frame_done   = 1'b1;
      end else if (!b_end) begin
        phase_nxt  = PH_PAYLOAD;
        remain_nxt = len_nxt;
        kidx_nxt   = '0;
        res_valid  = 1'b1;
        res_beat.kind         = KIND_HEADER;
        res_beat.fin_flag     = fin_nxt;
        res_beat.frame_opcode = opc_nxt;
        res_beat.mask_present = mask_nxt;
        res_beat.key_word     = key_nxt;
        res_beat.payload_size = len_nxt;
      end
    end

    // Buffer ends inside the header: truncation
    if (b_end && !res_valid && phase_r != PH_PAYLOAD && phase_r != PH_DROP) begin
      res_valid = 1'b1;
      res_beat  = '0;
      res_beat.kind = KIND_TRUNC;
    end

    if (b_end) phase_nxt = PH_HDR0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      cnt_r    <= '0;
      fin_r    <= 1'b0;
      opc_r    <= '0;
      mask_r   <= 1'b0;
      key_r    <= '0;
      len_r    <= '0;
      remain_r <= '0;
      kidx_r   <= '0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      fin_r    <= fin_nxt;
      opc_r    <= opc_nxt;
      mask_r   <= mask_nxt;
      key_r    <= key_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
      kidx_r   <= kidx_nxt;
    end
  end

  wsd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (in_acc && res_valid),
    .s_beat    (res_beat),
    .s_stall   (buf_stall),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .out_stall (out_stall)
  );

  assign in_stall = buf_stall;

endmodule

@@ rtl/wsd_out_buf.sv @@
// Output register with skid stage for deframer results.
`timescale 1ns / 1ps

module wsd_out_buf
  import wsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s_valid,
  input  out_beat_t s_beat,
  output logic      s_stall,
  output logic      out_valid,
  output out_beat_t out_beat,
  input  logic      out_stall
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_beat_t out_beat_r, out_beat_nxt;
  out_beat_t skid_beat_r, skid_beat_nxt;
  logic      take;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_beat_nxt   = out_beat_r;
    skid_beat_nxt  = skid_beat_r;
    if (skid_valid_r) begin
      if (take) begin
        out_beat_nxt   = skid_beat_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (s_valid) begin
      if (!out_valid_r || take) begin
        out_beat_nxt  = s_beat;
        out_valid_nxt = 1'b1;
      end else begin
        skid_beat_nxt  = s_beat;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r  <= out_beat_nxt;
    skid_beat_r <= skid_beat_nxt;
  end

  assign s_stall   = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

@@ test/websocket_frame_deframer_tb.sv @@
// Testbench for websocket_frame_deframer: directed table plus random buffers vs. a predictor.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb
  import wsd_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BEATS    = 140;
  localparam int DRAIN_CYCLES   = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
    logic       typed;    // expected result given in the row itself
    logic       has_res;
    out_beat_t  res;
  } stim_row_t;

  localparam out_beat_t NO_RES    = '0;
  localparam out_beat_t TRUNC_RES = '{KIND_TRUNC, 1'b0, 4'h0, 1'b0, 32'h0, 64'h0, 8'h0, 1'b0};

  // Directed buffers: lone first byte, empty ping closed by the buffer end,
  // 16-bit length with RSV bits set and trailing bytes, 64-bit length cut
  // short, masked frame cut mid-payload.
  localparam stim_row_t DIRECTED_ROWS [23] = '{
    '{8'h81, 1'b1, 1'b1, 1'b1, TRUNC_RES},
    '{8'h89, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b1, 1'b1,
      '{KIND_HEADER, 1'b1, 4'h9, 1'b0, 32'h0, 64'h0, 8'h0, 1'b1}},
    '{8'h7A, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h7E, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h02, 1'b0, 1'b1, 1'b1,
      '{KIND_HEADER, 1'b0, 4'hA, 1'b0, 32'h0, 64'h2, 8'h0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h55, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'hAA, 1'b1, 1'b1, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b1, 1'b1, TRUNC_RES},
    '{8'h8F, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h83, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h12, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h34, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h56, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h78, 1'b0, 1'b1, 1'b1,
      '{KIND_HEADER, 1'b1, 4'hF, 1'b1, 32'h12345678, 64'h3, 8'h0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b1, 1'b1, TRUNC_RES}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_beat   = '0;
  logic      in_stall;
  logic      out_valid;
  out_beat_t out_beat;
  logic      out_stall = 1'b0;

  websocket_frame_deframer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_beat   (in_beat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .out_stall (out_stall)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stim_row_t byte_feed [$];
  stim_row_t cur_row = '0;
  out_beat_t pending_results [$];
  int        idle_pct     = 0;
  int        stall_pct    = 0;
  int        fails        = 0;
  int        quiet_cycles = 0;

  // Parser state mirror
  phase_t      ps_phase = PH_HDR0;
  logic [2:0]  ps_count = '0;
  logic        ps_fin   = 1'b0;
  logic [3:0]  ps_opcode = '0;
  logic        ps_mask  = 1'b0;
  logic [31:0] ps_key   = '0;
  logic [63:0] ps_len   = '0;
  logic [63:0] ps_idx   = '0;

  function automatic out_beat_t frame_result(kind_t k, logic [7:0] data, logic done);
    out_beat_t r;
    r.kind         = k;
    r.fin_flag     = ps_fin;
    r.frame_opcode = ps_opcode;
    r.mask_present = ps_mask;
    r.key_word     = ps_key;
    r.payload_size = ps_len;
    r.payload_data = data;
    r.frame_done   = done;
    return r;
  endfunction

  // Last header byte seen: empty frame is done, otherwise payload follows
  // unless the buffer already ends here.
  task automatic close_header(input logic eob, output bit got, output out_beat_t r);
    got = 1'b1;
    if (ps_len == 64'd0) begin
      ps_phase = PH_DROP;
      r = frame_result(KIND_HEADER, 8'h00, 1'b1);
    end else if (eob) begin
      r = TRUNC_RES;
    end else begin
      ps_phase = PH_PAYLOAD;
      ps_idx = '0;
      r = frame_result(KIND_HEADER, 8'h00, 1'b0);
    end
  endtask

  task automatic deframe_byte(input in_beat_t bt, output bit got, output out_beat_t r);
    logic [7:0] b;
    logic       eob;
    logic [6:0] l7;
    logic [7:0] kb;
    logic       last;
    int         k;
    phase_t     entry;
    b = bt.data_byte;
    eob = bt.buffer_end;
    got = 1'b0;
    r = '0;
    entry = ps_phase;
    case (ps_phase)
      PH_HDR0: begin
        ps_fin = b[7];
        ps_opcode = b[3:0];
        ps_mask = 1'b0;
        ps_key = '0;
        ps_len = '0;
        ps_idx = '0;
        ps_count = '0;
        ps_phase = PH_HDR1;
      end
      PH_HDR1: begin
        l7 = b[6:0];
        ps_mask = b[7];
        ps_count = '0;
        if (l7 == LEN_ESC16) begin
          ps_phase = PH_EXT16;
        end else if (l7 == LEN_ESC64) begin
          ps_phase = PH_EXT64;
        end else begin
          ps_len = {57'd0, l7};
          if (ps_mask) ps_phase = PH_KEY;
          else close_header(eob, got, r);
        end
      end
      PH_EXT16, PH_EXT64: begin
        ps_len = {ps_len[55:0], b};
        ps_count = ps_count + 3'd1;
        if (ps_count == ((ps_phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
          ps_count = '0;
          if (ps_mask) ps_phase = PH_KEY;
          else close_header(eob, got, r);
        end
      end
      PH_KEY: begin
        ps_key = {ps_key[23:0], b};
        ps_count = ps_count + 3'd1;
        if (ps_count == KEY_BYTES) begin
          ps_count = '0;
          close_header(eob, got, r);
        end
      end
      PH_PAYLOAD: begin
        k = int'(ps_idx[1:0]);
        kb = ps_key[31 - 8*k -: 8];
        last = (ps_idx + 64'd1 == ps_len);
        got = 1'b1;
        if (eob && !last) r = TRUNC_RES;
        else r = frame_result(KIND_DATA, b ^ kb, last);
        ps_idx = ps_idx + 64'd1;
        if (last) ps_phase = PH_DROP;
      end
      default: begin
      end
    endcase
    if (eob && !got && entry != PH_DROP) begin
      got = 1'b1;
      r = TRUNC_RES;
    end
    if (eob) ps_phase = PH_HDR0;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      fails++;
    end
  endtask

  task automatic check_result(input out_beat_t seen);
    out_beat_t want;
    if (pending_results.size() == 0) begin
      $error("result beat with nothing pending: kind %0d", seen.kind);
      fails++;
    end else begin
      want = pending_results.pop_front();
      compare_field("kind", want.kind, seen.kind);
      compare_field("fin_flag", want.fin_flag, seen.fin_flag);
      compare_field("frame_opcode", want.frame_opcode, seen.frame_opcode);
      compare_field("mask_present", want.mask_present, seen.mask_present);
      compare_field("key_word", want.key_word, seen.key_word);
      compare_field("payload_size", want.payload_size, seen.payload_size);
      compare_field("payload_data", want.payload_data, seen.payload_data);
      compare_field("frame_done", want.frame_done, seen.frame_done);
    end
  endtask

  function automatic stim_row_t plain_row(logic [7:0] data, logic eob);
    stim_row_t r;
    r = '0;
    r.data = data;
    r.eob = eob;
    return r;
  endfunction

  // One buffer holding a frame with random header and content; some are cut short.
  task automatic queue_frame(inout int beats);
    logic [7:0]  raw [$];
    logic [63:0] len;
    logic        masked;
    int          mode;
    int          body;
    int          cut;
    masked = 1'($urandom_range(0, 1));
    raw.push_back(8'($urandom));
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 125))
                                        : 64'($urandom_range(0, 12));
      raw.push_back({masked, len[6:0]});
    end else if (mode < 8) begin
      len = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 65535))
                                        : 64'($urandom_range(0, 20));
      raw.push_back({masked, LEN_ESC16});
      raw.push_back(len[15:8]);
      raw.push_back(len[7:0]);
    end else begin
      len = ($urandom_range(0, 2) == 0) ? {32'($urandom), 32'($urandom)}
                                        : 64'($urandom_range(0, 20));
      raw.push_back({masked, LEN_ESC64});
      for (int i = 7; i >= 0; i--) raw.push_back(len[8*i +: 8]);
    end
    if (masked) repeat (4) raw.push_back(8'($urandom));
    body = (len > 64'd48) ? 48 : int'(len);
    repeat (body) raw.push_back(8'($urandom));
    if (len <= 64'd48) repeat ($urandom_range(0, 3)) raw.push_back(8'($urandom));
    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, raw.size()) : raw.size();
    for (int i = 0; i < cut; i++) byte_feed.push_back(plain_row(raw[i], i == cut - 1));
    beats += cut;
  endtask

  task automatic queue_noise(inout int beats);
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      byte_feed.push_back(plain_row(8'($urandom), (i == n - 1) || ($urandom_range(0, 7) == 0)));
    beats += n;
  endtask

  // Sender: a beat stays up until taken; idling is decided only between beats.
  always @(posedge clk) begin : drive
    bit        got;
    out_beat_t want;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_beat, got, want);
        if (cur_row.typed) begin
          got = cur_row.has_res;
          want = cur_row.res;
        end
        if (got) pending_results.push_back(want);
      end
      if (!in_valid || !in_stall) begin
        if (byte_feed.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_row = byte_feed.pop_front();
          in_valid <= 1'b1;
          in_beat <= {cur_row.data, cur_row.eob};
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_beat);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("websocket_frame_deframer regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int beats;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[i]) byte_feed.push_back(DIRECTED_ROWS[i]);
    // phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 15 : 0;
      stall_pct = (ph == 2) ? 60 : (ph == 3) ? 15 : 0;
      beats = 0;
      while (beats < PHASE_BEATS) begin
        if ($urandom_range(0, 99) < 85) queue_frame(beats);
        else queue_noise(beats);
      end
      while (byte_feed.size() != 0 || in_valid) @(negedge clk);
    end
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("websocket_frame_deframer regression: pass");
    end else begin
      $display("websocket_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule
